### rtl/strip_pedestal_coincidence_map_assert.svh
// Assertion macros shared by the checker files.
`ifndef STRIP_PEDESTAL_COINCIDENCE_MAP_ASSERT_SVH
`define STRIP_PEDESTAL_COINCIDENCE_MAP_ASSERT_SVH
// next-cycle implication, ignored while reset is asserted
`define SPCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
// next-cycle implication, also checked through reset
`define SPCM_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("assertion failed");
// same-cycle implication, also checked through reset
`define SPCM_ASSERT_NOW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("assertion failed");
`endif

### rtl/spcm_pkg.sv
// ----------------------------------------------------------------------------
// spcm_pkg
// Shared constants, codes and types of the strip coincidence map block.
// ----------------------------------------------------------------------------
package spcm_pkg;

  localparam int STRIPS_DEF      = 128;
  localparam int TIME_SLOTS_DEF  = 512;
  localparam int SAMPLE_BITS_DEF = 20;

  localparam int CFG_W = 12;
  localparam int SUM_W = 48;

  // input word kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // queued operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SKIP   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  // register indexes
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [CFG_W-1:0] OFFSET_RST = 12'd72;
  localparam logic [CFG_W-1:0] THRESH_RST = 12'd16;

  typedef struct packed {
    logic [CFG_W-1:0] offset;
    logic [CFG_W-1:0] thresh;
  } cfg_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
    logic [2:0] top;
    top = v[SUM_W+1:SUM_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[SUM_W-1:0];
    end else if (v[SUM_W+1]) begin
      return {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/strip_pedestal_coincidence_map.sv
// ----------------------------------------------------------------------------
// strip_pedestal_coincidence_map
// Pedestal-subtracted x/y strip coincidence map with APB register access.
// ----------------------------------------------------------------------------
// Sample word: steps are pop, pedestal read and store write; the next word is popped after the write.
// Read word: steps are pop, map read and output register; the map wait state holds while the receiver stalls.
// Group end or flush: per time slot a load pass over all 2*STRIPS channels, a drain step,
//   an x scan over the strips, a y scan per hit x strip and an accumulate step per hit pair.
// Reset: a clearing pass over max(TIME_SLOTS*2*STRIPS, STRIPS*STRIPS) addresses
//   zeroes the frame, map and pedestal stores; in_ready stays low until it ends.
module strip_pedestal_coincidence_map import spcm_pkg::*; #(
  parameter int STRIPS      = STRIPS_DEF,
  parameter int TIME_SLOTS  = TIME_SLOTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [8:0]                    in_time_slot,
  input  logic [8:0]                    in_strip_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [7:0]                    in_bin_x,
  input  logic [7:0]                    in_bin_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SUM_W-1:0]       out_bin_sum
);

  localparam int XW = $clog2(STRIPS);
  localparam int CW = $clog2(2 * STRIPS);
  localparam int TW = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
  localparam int W  = 3 + TW + CW + SAMPLE_BITS + 2 * XW;

  cfg_t         cfg_r;
  logic         push, q_full, q_valid, q_pop, clearing;
  logic [W-1:0] push_data, q_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset <= OFFSET_RST;
      cfg_r.thresh <= THRESH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_OFFSET: cfg_r.offset <= pwdata[CFG_W-1:0];
        REG_THRESH: cfg_r.thresh <= pwdata[CFG_W-1:0];
        default:    cfg_r.offset <= cfg_r.offset;
      endcase
    end
  end

  assign prdata = {20'd0, (paddr[2] == REG_THRESH) ? cfg_r.thresh : cfg_r.offset};

  spcm_front #(
    .STRIPS(STRIPS), .TIME_SLOTS(TIME_SLOTS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_time_slot     (in_time_slot),
    .in_strip_channel (in_strip_channel),
    .in_sample_value  (in_sample_value),
    .in_bin_x         (in_bin_x),
    .in_bin_y         (in_bin_y),
    .clearing         (clearing),
    .q_full           (q_full),
    .push             (push),
    .push_data        (push_data)
  );

  spcm_queue #(.W(W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  spcm_back #(
    .STRIPS(STRIPS), .TIME_SLOTS(TIME_SLOTS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bin_sum (out_bin_sum)
  );

endmodule

### rtl/spcm_queue.sv
// ----------------------------------------------------------------------------
// spcm_queue
// Two-entry queue between the classifying front and the processing back.
// ----------------------------------------------------------------------------
module spcm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] data,
  input  logic         pop
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign data  = mem_r[rp_r];

endmodule

### rtl/spcm_front.sv
// ----------------------------------------------------------------------------
// spcm_front
// Accepts input words, range-checks them and packs them into queue entries.
// ----------------------------------------------------------------------------
module spcm_front import spcm_pkg::*; #(
  parameter int STRIPS      = STRIPS_DEF,
  parameter int TIME_SLOTS  = TIME_SLOTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int XW = $clog2(STRIPS),
  localparam int CW = $clog2(2 * STRIPS),
  localparam int TW = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1,
  localparam int W  = 3 + TW + CW + SAMPLE_BITS + 2 * XW
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [8:0]                    in_time_slot,
  input  logic [8:0]                    in_strip_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [7:0]                    in_bin_x,
  input  logic [7:0]                    in_bin_y,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          push,
  output logic [W-1:0]                  push_data
);

  logic [1:0]    op;
  logic          ok, ch_ok, slot_ok, bin_ok;
  logic [TW-1:0] slot;
  logic [CW-1:0] chan;
  logic [XW-1:0] bx, by;

  always_comb begin
    ch_ok   = (in_strip_channel != 9'd0) && ({23'd0, in_strip_channel} <= 32'(2 * STRIPS));
    slot_ok = {23'd0, in_time_slot} < 32'(TIME_SLOTS);
    bin_ok  = (in_bin_x != 8'd0) && ({24'd0, in_bin_x} <= 32'(STRIPS)) &&
              (in_bin_y != 8'd0) && ({24'd0, in_bin_y} <= 32'(STRIPS));
    op = OP_SKIP;
    ok = 1'b0;
    case (in_kind)
      KIND_SAMPLE: begin
        op = (ch_ok && slot_ok) ? OP_SAMPLE : OP_SKIP;
      end
      KIND_READ: begin
        op = OP_READ;
        ok = bin_ok;
      end
      KIND_FLUSH: begin
        op = OP_FLUSH;
      end
      default: begin
        op = OP_SKIP;
      end
    endcase
  end

  assign slot = TW'(in_time_slot);
  assign chan = CW'(in_strip_channel - 9'd1);
  assign bx   = XW'(in_bin_x - 8'd1);
  assign by   = XW'(in_bin_y - 8'd1);

  assign in_ready  = !q_full && !clearing;
  // unused kind is taken and dropped here
  assign push      = in_valid && in_ready && (in_kind != KIND_NONE);
  assign push_data = {op, ok, slot, chan, in_sample_value, bx, by};

endmodule

### rtl/spcm_back.sv
// ----------------------------------------------------------------------------
// spcm_back
// Sequencer that owns the pedestal, frame and map stores: applies samples,
// answers reads and runs the per-group coincidence scan.
// ----------------------------------------------------------------------------
module spcm_back import spcm_pkg::*; #(
  parameter int STRIPS      = STRIPS_DEF,
  parameter int TIME_SLOTS  = TIME_SLOTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int XW = $clog2(STRIPS),
  localparam int CW = $clog2(2 * STRIPS),
  localparam int TW = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1,
  localparam int W  = 3 + TW + CW + SAMPLE_BITS + 2 * XW
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    q_valid,
  input  logic [W-1:0]            q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_bin_sum
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CH  = 2 * STRIPS;
  localparam int FW  = SB + 1;
  localparam int EW  = ((SB > CFG_W) ? SB : CFG_W) + 3;
  localparam int FD  = TIME_SLOTS * CH;
  localparam int MD  = STRIPS * STRIPS;
  localparam int FAW = $clog2(FD);
  localparam int MAW = $clog2(MD);
  localparam int CLR_LEN = (FD > MD) ? FD : MD;
  localparam int CLW = $clog2(CLR_LEN);
  localparam int AW  = XW + 1;

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_SAMP_RD  = 4'd2;
  localparam logic [3:0] ST_SAMP_WR  = 4'd3;
  localparam logic [3:0] ST_MAP_RD   = 4'd4;
  localparam logic [3:0] ST_MAP_WAIT = 4'd5;
  localparam logic [3:0] ST_LOAD     = 4'd6;
  localparam logic [3:0] ST_DRAIN    = 4'd7;
  localparam logic [3:0] ST_XSTEP    = 4'd8;
  localparam logic [3:0] ST_YSTEP    = 4'd9;
  localparam logic [3:0] ST_ACC      = 4'd10;

  // queue entry fields
  logic [1:0]          q_op;
  logic                q_ok;
  logic [TW-1:0]       q_slot;
  logic [CW-1:0]       q_chan;
  logic [SB-1:0]       q_val;
  logic [XW-1:0]       q_bx, q_by;

  logic [3:0]          state_r, state_nxt;
  logic [CLW-1:0]      clr_idx_r;
  logic                ok_r, samp_ok_r;
  logic [TW-1:0]       slot_r, t_r;
  logic [CW-1:0]       chan_r, lc_r, ld_c_r;
  logic [SB-1:0]       val_r;
  logic [XW-1:0]       bx_r, by_r;
  logic [FAW-1:0]      grp_pos_r, faddr_r;
  logic                past_r, ld_v_r;
  logic [AW-1:0]       a_r, b_r;
  logic [MAW-1:0]      mbase_r;
  logic [STRIPS-1:0]   xhit_r, yhit_r;
  logic                out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;

  // stores
  logic [FW-1:0]    frame_mem [FD];
  logic [SUM_W-1:0] map_mem [MD];
  logic [SB-1:0]    ped_mem [CH];
  logic [FW-1:0]    xmem [STRIPS];
  logic [FW-1:0]    ymem [STRIPS];
  logic [FW-1:0]    fr_q, xq, yq;
  logic [SUM_W-1:0] map_q;
  logic [SB-1:0]    ped_q;

  logic             fr_we, map_we, ped_we;
  logic [FAW-1:0]   fr_waddr, fr_raddr;
  logic [FW-1:0]    fr_wdata;
  logic [MAW-1:0]   map_waddr, map_raddr, pair_addr;
  logic [SUM_W-1:0] map_wdata;
  logic [CW-1:0]    ped_waddr;
  logic [SB-1:0]    ped_wdata;

  logic signed [EW-1:0] v_full, d_full, ld_ext, cut;
  logic [SB-1:0]        ped_sat;
  logic [FW-1:0]        fr_sat;
  logic                 ld_hit, ld_is_x, out_load, last_pos;
  logic signed [SUM_W+1:0] acc_sum;

  assign {q_op, q_ok, q_slot, q_chan, q_val, q_bx, q_by} = q_data;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign clearing = (state_r == ST_CLR);
  assign out_load = !out_valid_r || out_ready;
  assign last_pos = (grp_pos_r == FAW'(FD - 1));
  assign pair_addr = mbase_r + MAW'(b_r);

  // sample arithmetic
  always_comb begin
    v_full = {{(EW-SB){val_r[SB-1]}}, val_r} - {{(EW-CFG_W){1'b0}}, cfg.offset};
    d_full = v_full - {{(EW-SB){ped_q[SB-1]}}, ped_q};
    if (&v_full[EW-1:SB-1] || ~|v_full[EW-1:SB-1]) begin
      ped_sat = v_full[SB-1:0];
    end else begin
      ped_sat = v_full[EW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    if (&d_full[EW-1:FW-1] || ~|d_full[EW-1:FW-1]) begin
      fr_sat = d_full[FW-1:0];
    end else begin
      fr_sat = d_full[EW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    end
  end

  // hit test of the word coming back from the frame store
  assign ld_ext  = {{(EW-FW){fr_q[FW-1]}}, fr_q};
  assign cut     = -$signed({{(EW-CFG_W){1'b0}}, cfg.thresh});
  assign ld_hit  = ld_ext < cut;
  assign ld_is_x = 32'(ld_c_r) < STRIPS;

  assign acc_sum = {{2{map_q[SUM_W-1]}}, map_q}
                 + {{(SUM_W+2-FW){xq[FW-1]}}, xq}
                 + {{(SUM_W+2-FW){yq[FW-1]}}, yq};

  // store port control
  always_comb begin
    fr_we     = 1'b0;
    fr_waddr  = faddr_r;
    fr_wdata  = '0;
    fr_raddr  = faddr_r;
    map_we    = 1'b0;
    map_waddr = pair_addr;
    map_wdata = sat_sum(acc_sum);
    map_raddr = pair_addr;
    ped_we    = 1'b0;
    ped_waddr = chan_r;
    ped_wdata = ped_sat;
    case (state_r)
      ST_CLR: begin
        fr_we     = 32'(clr_idx_r) < FD;
        fr_waddr  = clr_idx_r[FAW-1:0];
        map_we    = 32'(clr_idx_r) < MD;
        map_waddr = clr_idx_r[MAW-1:0];
        map_wdata = '0;
        ped_we    = 32'(clr_idx_r) < CH;
        ped_waddr = clr_idx_r[CW-1:0];
        ped_wdata = '0;
      end
      ST_SAMP_WR: begin
        fr_waddr = FAW'(32'(slot_r) * CH + 32'(chan_r));
        fr_wdata = fr_sat;
        fr_we    = samp_ok_r && past_r;
        ped_we   = samp_ok_r && !past_r;
      end
      // bin address held while the result waits for the receiver
      ST_MAP_RD, ST_MAP_WAIT: begin
        map_raddr = MAW'(32'(bx_r) * STRIPS + 32'(by_r));
      end
      ST_LOAD: begin
        // read old frame word and zero it in the same cycle
        fr_we = 1'b1;
      end
      ST_ACC: begin
        map_we = 1'b1;
      end
      default: begin
        fr_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fr_we) frame_mem[fr_waddr] <= fr_wdata;
    fr_q <= frame_mem[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (ped_we) ped_mem[ped_waddr] <= ped_wdata;
    ped_q <= ped_mem[chan_r];
  end

  always_ff @(posedge clk) begin
    if (ld_v_r && ld_is_x) xmem[XW'(ld_c_r)] <= fr_q;
    xq <= xmem[a_r[XW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ld_v_r && !ld_is_x) ymem[XW'(32'(ld_c_r) - STRIPS)] <= fr_q;
    if (state_r == ST_YSTEP) yq <= ymem[b_r[XW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_idx_r == CLW'(CLR_LEN - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_op)
            OP_READ:  state_nxt = ST_MAP_RD;
            OP_FLUSH: state_nxt = ST_LOAD;
            default:  state_nxt = ST_SAMP_RD;
          endcase
        end
      end
      ST_SAMP_RD:  state_nxt = ST_SAMP_WR;
      ST_SAMP_WR:  state_nxt = last_pos ? ST_LOAD : ST_IDLE;
      ST_MAP_RD:   state_nxt = ST_MAP_WAIT;
      ST_MAP_WAIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        if (lc_r == CW'(CH - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:    state_nxt = ST_XSTEP;
      ST_XSTEP: begin
        if (a_r == AW'(STRIPS)) begin
          state_nxt = (t_r == TW'(TIME_SLOTS - 1)) ? ST_IDLE : ST_LOAD;
        end else if (xhit_r[a_r[XW-1:0]]) begin
          state_nxt = ST_YSTEP;
        end
      end
      ST_YSTEP: begin
        if (b_r == AW'(STRIPS)) begin
          state_nxt = ST_XSTEP;
        end else if (yhit_r[b_r[XW-1:0]]) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:      state_nxt = ST_YSTEP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      grp_pos_r   <= '0;
      past_r      <= 1'b0;
      faddr_r     <= '0;
      lc_r        <= '0;
      t_r         <= '0;
      ld_v_r      <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      mbase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_v_r      <= (state_r == ST_LOAD);
      out_valid_r <= ((state_r == ST_MAP_WAIT) && out_load) || (out_valid_r && !out_ready);
      case (state_r)
        ST_CLR: begin
          clr_idx_r <= clr_idx_r + CLW'(1);
        end
        ST_IDLE: begin
          if (q_valid && q_op == OP_FLUSH) begin
            grp_pos_r <= '0;
            faddr_r   <= '0;
            lc_r      <= '0;
            t_r       <= '0;
          end
        end
        ST_SAMP_WR: begin
          if (last_pos) begin
            grp_pos_r <= '0;
            faddr_r   <= '0;
            lc_r      <= '0;
            t_r       <= '0;
          end else begin
            grp_pos_r <= grp_pos_r + FAW'(1);
          end
        end
        ST_LOAD: begin
          faddr_r <= faddr_r + FAW'(1);
          lc_r    <= (lc_r == CW'(CH - 1)) ? '0 : lc_r + CW'(1);
        end
        ST_DRAIN: begin
          a_r     <= '0;
          mbase_r <= '0;
        end
        ST_XSTEP: begin
          if (a_r == AW'(STRIPS)) begin
            if (t_r == TW'(TIME_SLOTS - 1)) begin
              past_r <= 1'b1;
            end else begin
              t_r <= t_r + TW'(1);
            end
          end else if (xhit_r[a_r[XW-1:0]]) begin
            b_r <= '0;
          end else begin
            a_r     <= a_r + AW'(1);
            mbase_r <= mbase_r + MAW'(STRIPS);
          end
        end
        ST_YSTEP: begin
          if (b_r == AW'(STRIPS)) begin
            a_r     <= a_r + AW'(1);
            mbase_r <= mbase_r + MAW'(STRIPS);
          end else if (!yhit_r[b_r[XW-1:0]]) begin
            b_r <= b_r + AW'(1);
          end
        end
        ST_ACC: begin
          b_r <= b_r + AW'(1);
        end
        default: begin
          clr_idx_r <= clr_idx_r;
        end
      endcase
    end
  end

  // word and slot payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ok_r      <= q_ok;
      samp_ok_r <= (q_op == OP_SAMPLE);
      slot_r    <= q_slot;
      chan_r    <= q_chan;
      val_r     <= q_val;
      bx_r      <= q_bx;
      by_r      <= q_by;
    end
    if (ld_v_r) begin
      if (ld_is_x) xhit_r[XW'(ld_c_r)] <= ld_hit;
      else yhit_r[XW'(32'(ld_c_r) - STRIPS)] <= ld_hit;
    end
    ld_c_r <= lc_r;
    if (state_r == ST_MAP_WAIT && out_load) begin
      out_sum_r <= ok_r ? map_q : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_bin_sum = out_sum_r;

endmodule

### rtl/strip_pedestal_coincidence_map_chk.sv
// ----------------------------------------------------------------------------
// strip_pedestal_coincidence_map_chk
// Port-level checks of the coincidence map block, bound to the top level.
// ----------------------------------------------------------------------------
`include "strip_pedestal_coincidence_map_assert.svh"

module strip_pedestal_coincidence_map_chk import spcm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] out_bin_sum
);

  // a stalled result word holds
  `SPCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bin_sum))
  // reset drops any pending result
  `SPCM_ASSERT_NEXT_ANY(a_rst_out, clk, !rst_n, !out_valid)
  // store clearing runs right after reset, so no word is taken then
  `SPCM_ASSERT_NOW(a_rst_clear, clk, $rose(rst_n), !in_ready)

endmodule

bind strip_pedestal_coincidence_map strip_pedestal_coincidence_map_chk u_chk (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the strip coincidence map block. Sample, read and flush words go in
// through the valid/ready input channel while a scoreboard keeps its own copy
// of pedestals, frames and map bins. Each returned bin_sum is checked in
// order. Registers are rewritten between phases through the APB port, and
// sender idling and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
import spcm_pkg::*;

class coincidence_scoreboard;
  int unsigned   offset;
  int unsigned   thresh;
  bit            past_first;
  int            pedestal[256];
  int            frame_val[int];     // key: slot*256 + channel index
  longint        map_bin[int];       // key: x*128 + y, zero based
  int            hit_bins[$];
  longint        pending_sums[$];
  int            errors;

  function new();
    offset = OFFSET_RST;
    thresh = THRESH_RST;
    past_first = 0;
    errors = 0;
    foreach (pedestal[i]) pedestal[i] = 0;
  endfunction

  function longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function void close_group();
    bit     slot_used[512];
    int     xs[$];
    int     ys[$];
    int     key;
    longint acc;
    foreach (frame_val[k]) slot_used[k / 256] = 1;
    for (int t = 0; t < 512; t++) begin
      if (!slot_used[t]) continue;
      xs.delete();
      ys.delete();
      for (int k = 0; k < 128; k++) begin
        if (frame_val.exists(t*256 + k) && frame_val[t*256 + k] < -int'(thresh))
          xs.push_back(k);
        if (frame_val.exists(t*256 + 128 + k) && frame_val[t*256 + 128 + k] < -int'(thresh))
          ys.push_back(k);
      end
      foreach (xs[a]) begin
        foreach (ys[b]) begin
          key = xs[a]*128 + ys[b];
          if (!map_bin.exists(key)) begin
            map_bin[key] = 0;
            hit_bins.push_back(key);
          end
          acc = map_bin[key] + frame_val[t*256 + xs[a]] + frame_val[t*256 + 128 + ys[b]];
          map_bin[key] = clip(acc, SUM_W);
        end
      end
    end
    frame_val.delete();
    past_first = 1;
  endfunction

  function void note_word(logic [1:0] kind, logic [8:0] slot, logic [8:0] ch,
                          logic signed [19:0] val, logic [7:0] bx, logic [7:0] by);
    longint v;
    int     key;
    case (kind)
      KIND_SAMPLE: begin
        v = longint'(val) - longint'(offset);
        if (ch >= 1 && ch <= 256) begin
          if (!past_first) pedestal[ch-1] = int'(clip(v, 20));
          else frame_val[slot*256 + ch - 1] = int'(clip(v - pedestal[ch-1], 21));
        end
      end
      KIND_READ: begin
        key = (int'(bx) - 1)*128 + int'(by) - 1;
        if (bx >= 1 && bx <= 128 && by >= 1 && by <= 128 && map_bin.exists(key))
          pending_sums.push_back(map_bin[key]);
        else
          pending_sums.push_back(0);
      end
      KIND_FLUSH: close_group();
      default: ;
    endcase
  endfunction

  function void check_sum(logic signed [SUM_W-1:0] got);
    logic signed [SUM_W-1:0] want;
    if (pending_sums.size() == 0) begin
      $display("%0t: unexpected word, bin_sum %0d", $time, got);
      errors++;
      return;
    end
    want = pending_sums.pop_front();
    if (got !== want) begin
      $display("%0t: bin_sum mismatch, expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic                     clk;
  logic                     rst_n;
  logic                     psel, penable, pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid, in_ready;
  logic [1:0]               in_kind;
  logic [8:0]               in_time_slot, in_strip_channel;
  logic signed [19:0]       in_sample_value;
  logic [7:0]               in_bin_x, in_bin_y;
  logic                     out_valid, out_ready;
  logic signed [SUM_W-1:0]  out_bin_sum;

  coincidence_scoreboard sb = new();
  int          idle_pct;
  int          stall_pct;
  longint      cycles;
  int          hot_slots[8];

  strip_pedestal_coincidence_map dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 12_000_000) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sum(out_bin_sum);
    out_ready <= ($urandom % 100) >= stall_pct;
  end

  task automatic send_word(logic [1:0] kind, logic [8:0] slot, logic [8:0] ch,
                           logic signed [19:0] val, logic [7:0] bx, logic [7:0] by);
    while (($urandom % 100) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_time_slot <= slot;
    in_strip_channel <= ch;
    in_sample_value <= val;
    in_bin_x <= bx;
    in_bin_y <= by;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(kind, slot, ch, val, bx, by);
  endtask

  task automatic read_bin(int key);
    send_word(KIND_READ, $urandom, $urandom, $urandom, key/128 + 1, key%128 + 1);
  endtask

  task automatic read_any();
    if (sb.hit_bins.size() > 0 && $urandom_range(1))
      read_bin(sb.hit_bins[$urandom_range(sb.hit_bins.size() - 1)]);
    else
      send_word(KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // wait out everything in flight; a trailing read guarantees a flush is done
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] value);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= idx ? 3'd4 : 3'd0;
    pwdata <= {20'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    if (idx == REG_THRESH) sb.thresh = value;
    else sb.offset = value;
  endtask

  // one word: mostly a sample aimed at hot slots with a chosen frame value
  task automatic frame_sample(int lo, int hi);
    int     ch;
    longint v;
    int     r;
    r = $urandom % 100;
    if (r < 12) begin
      send_word(r < 2 ? KIND_NONE : KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    end else if (r < 22) begin
      read_any();
    end else begin
      ch = $urandom_range(256, 1);
      v = longint'(sb.pedestal[ch-1]) + longint'(sb.offset) + longint'(lo)
        + longint'($urandom_range(hi - lo));
      send_word(KIND_SAMPLE, hot_slots[$urandom % 8], ch, 20'(sb.clip(v, 20)), $urandom,
                $urandom);
    end
  endtask

  task automatic flush_and_read(int reads);
    send_word(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (reads) read_any();
    drain();
  endtask

  initial begin
    rst_n <= 0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    in_valid <= 0; in_kind <= 0; in_time_slot <= 0; in_strip_channel <= 0;
    in_sample_value <= 0; in_bin_x <= 0; in_bin_y <= 0;
    out_ready <= 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    foreach (hot_slots[i]) hot_slots[i] = $urandom_range(511);
    hot_slots[0] = 0;
    hot_slots[1] = 511;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // pedestal group: channel edges, out-of-range channels, value extremes, an unused kind, bin reads
    send_word(KIND_SAMPLE, 0, 1, -20'sd524288, 0, 0);
    send_word(KIND_SAMPLE, 511, 128, 20'sd524287, 0, 0);
    send_word(KIND_SAMPLE, 5, 129, 20'sd100, 0, 0);
    send_word(KIND_SAMPLE, 5, 256, -20'sd100, 0, 0);
    send_word(KIND_SAMPLE, 5, 0, 20'sd7, 0, 0);
    send_word(KIND_SAMPLE, 5, 257, 20'sd7, 0, 0);
    send_word(KIND_SAMPLE, 5, 511, 20'sd7, 0, 0);
    send_word(KIND_NONE, 9'h1ff, 9'h1ff, -20'sd1, 8'hff, 8'hff);
    send_word(KIND_READ, 0, 0, 0, 0, 1);
    send_word(KIND_READ, 0, 0, 0, 1, 0);
    send_word(KIND_READ, 0, 0, 0, 129, 5);
    send_word(KIND_READ, 0, 0, 0, 255, 255);
    send_word(KIND_READ, 0, 0, 0, 128, 128);
    for (int c = 2; c < 128; c += 2)
      send_word(KIND_SAMPLE, $urandom, c, $urandom_range(400) - 200, 0, 0);
    for (int c = 130; c < 256; c += 3)
      send_word(KIND_SAMPLE, $urandom, c, $urandom_range(400) - 200, 0, 0);
    send_word(KIND_FLUSH, 0, 0, 0, 0, 0);
    send_word(KIND_READ, 0, 0, 0, 1, 1);
    drain();

    // frame groups at default settings, sender idling
    idle_pct = 68;
    repeat (160) frame_sample(-3000, 300);
    flush_and_read(30);

    // offset zero, top threshold, receiver stalling
    write_reg(REG_OFFSET, 12'd0);
    write_reg(REG_THRESH, 12'd4095);
    idle_pct = 0;
    stall_pct = 68;
    repeat (130) frame_sample(-9000, 0);
    flush_and_read(30);

    // top offset, zero threshold, light idling on both sides
    write_reg(REG_OFFSET, 12'd4095);
    write_reg(REG_THRESH, 12'd0);
    idle_pct = 10;
    stall_pct = 10;
    repeat (100) frame_sample(-600000, 600000);
    flush_and_read(40);

    in_valid <= 0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
